@@ rtl/dns_query_packet_builder_core_defines.svh @@
// Assertion macros for the DNS query builder.
`ifndef DNS_QUERY_PACKET_BUILDER_CORE_DEFINES_SVH
`define DNS_QUERY_PACKET_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DQPB_ASSERT_IMPL(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dqpb: implication check failed");
`define DQPB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dqpb: next-cycle check failed");
`else
`define DQPB_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define DQPB_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/dqpb_pkg.sv @@
package dqpb_pkg;

	localparam logic [7:0]  CHAR_END    = 8'h00;
	localparam logic [7:0]  CHAR_DOT    = 8'h2E;
	localparam logic [15:0] HDR_FLAGS   = 16'h0100;
	localparam logic [15:0] HDR_QDCOUNT = 16'h0001;
	localparam logic [15:0] QTYPE_A     = 16'h0001;
	localparam logic [15:0] QCLASS_IN   = 16'h0001;
	localparam logic [2:0]  HDR_LAST    = 3'd5;
	localparam int          TRL_BYTES   = 5;

	typedef struct packed {
		logic [7:0]  host_char;
		logic [15:0] query_id;
	} dqpb_in_t;

	typedef struct packed {
		logic [15:0] out_pair;
		logic [1:0]  byte_count;
		logic        last_of_run;
		logic        packet_end;
		logic        aborted;
	} dqpb_out_t;

	// one output beat as decided by the sequencer; label bytes come from the RAM
	typedef struct packed {
		logic [15:0] fixed;
		logic        hi_mem;
		logic        lo_mem;
		logic [1:0]  byte_count;
		logic        last_of_run;
		logic        packet_end;
		logic        aborted;
	} dqpb_issue_t;

	function automatic logic [15:0] hdr_pair(input logic [2:0] idx, input logic [15:0] id);
		logic [15:0] r;
		case (idx)
			3'd0:    r = id;
			3'd1:    r = HDR_FLAGS;
			3'd2:    r = HDR_QDCOUNT;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	// root label, then type and class
	function automatic logic [7:0] trailer_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = 8'h00;
			3'd1:    r = QTYPE_A[15:8];
			3'd2:    r = QTYPE_A[7:0];
			3'd3:    r = QCLASS_IN[15:8];
			3'd4:    r = QCLASS_IN[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/dns_query_packet_builder_core.sv @@
// DNS query body builder.
// Input channel (in_valid/in_stall/in_data): one hostname character per beat
// with the query id; a zero character ends the name. Output channel
// (out_valid/out_stall/out_data): big-endian byte pairs of the query body.
// Config: cfg_wr_en/cfg_wr_data load the server address; zero drops queries.
// The first character of a query emits 6 header beats. A label character
// emits no beats. A dot or terminator emits ceil((L+1)/2) or ceil((L+6)/2)
// beats for a label of L bytes, one per cycle unless the output stalls,
// read two bytes a cycle from the label RAM. in_stall is high while a run is
// being issued. A beat passes the RAM read stage, then the output register.
// An overlong name or label gives one aborted beat; the rest of that name
// is swallowed up to its terminator.
// A stalled receiver holds the output register; the sequencer stops issuing
// once the RAM read stage is full while the output register is held.
// Reset clears the server address and query control state; the block is idle.
`include "dns_query_packet_builder_core_defines.svh"
module dns_query_packet_builder_core import dqpb_pkg::*; #(
	parameter int LABEL_MAX  = 63,
	parameter int NAME_LIMIT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  dqpb_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output dqpb_out_t   out_data
);

	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	logic        s1_ready;
	logic        issue_go;
	dqpb_issue_t issue;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [7:0]  mem_wdata, rdata_a, rdata_b;

	dqpb_seq #(
		.LABEL_MAX  (LABEL_MAX),
		.NAME_LIMIT (NAME_LIMIT),
		.AW         (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.s1_ready    (s1_ready),
		.issue_go    (issue_go),
		.issue       (issue),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b)
	);

	dqpb_ram #(
		.WIDTH (8),
		.DEPTH (LABEL_MAX),
		.AW    (AW)
	) u_label_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	dqpb_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue_go  (issue_go),
		.issue     (issue),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.s1_ready  (s1_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`DQPB_ASSERT_IMPL(a_abort_beat, clk, arst_n, out_valid && out_data.aborted, out_data.packet_end && out_data.last_of_run && (out_data.byte_count == 2'd1))
	`DQPB_ASSERT_IMPL(a_end_is_last, clk, arst_n, out_valid && out_data.packet_end, out_data.last_of_run)
	`DQPB_ASSERT_IMPL(a_no_rw_same, clk, arst_n, mem_we, !mem_re)
	`DQPB_ASSERT_NEXT(a_store_no_read, clk, arst_n, mem_we, !mem_re)

endmodule

@@ rtl/dqpb_ram.sv @@
module dqpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

@@ rtl/dqpb_seq.sv @@
module dqpb_seq import dqpb_pkg::*; #(
	parameter int LABEL_MAX  = 63,
	parameter int NAME_LIMIT = 256,
	parameter int AW         = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  dqpb_in_t    in_data,
	input  logic        s1_ready,
	output logic        issue_go,
	output dqpb_issue_t issue,
	output logic        mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]  mem_wdata,
	output logic        mem_re,
	output logic [AW-1:0] mem_raddr_a,
	output logic [AW-1:0] mem_raddr_b
);

	localparam int LBL_W = $clog2(LABEL_MAX + 1);
	localparam int NM_W  = $clog2(NAME_LIMIT);
	localparam int J_W   = $clog2(LABEL_MAX + 8);
	localparam int JX    = J_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_HDR   = 4'b0010,
		ST_TAIL  = 4'b0100,
		ST_ABORT = 4'b1000
	} state_t;

	state_t           state_q;
	logic [2:0]       hcnt_q;
	logic [J_W-1:0]   j_q;
	logic [LBL_W-1:0] run_len_q;
	logic             term_q;
	logic             tail_q;
	logic [15:0]      id_q;
	logic [LBL_W-1:0] lbl_q;
	logic [NM_W-1:0]  name_q;
	logic             in_query_q;
	logic             discard_q;
	logic [31:0]      server_q;

	logic             accept;
	logic [7:0]       c;
	logic             is_end, is_dot;
	logic             start, proc, ab, tail, store;
	logic [LBL_W-1:0] cur_lbl;
	logic [NM_W-1:0]  cur_name;

	logic [JX-1:0]    jx, lx, m, hi_idx, lo_idx;
	logic             hi_mem, lo_mem, lo_any, t_last;
	logic [7:0]       hi_fixed, lo_fixed;
	logic [J_W-1:0]   j_m1;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign c        = in_data.host_char;
	assign is_end   = (c == CHAR_END);
	assign is_dot   = (c == CHAR_DOT);
	assign start    = !in_query_q && (server_q != '0);
	assign proc     = start || (in_query_q && !discard_q);
	assign cur_lbl  = start ? '0 : lbl_q;
	assign cur_name = start ? '0 : name_q;
	assign ab       = proc && !is_end
	                  && ((cur_name >= NM_W'(NAME_LIMIT - 1))
	                      || (!is_dot && (cur_lbl >= LBL_W'(LABEL_MAX))));
	assign tail     = proc && !ab && (is_dot || is_end);
	assign store    = proc && !ab && !is_dot && !is_end;

	assign mem_we    = accept && store;
	assign mem_waddr = cur_lbl[AW-1:0];
	assign mem_wdata = c;

	// tail run: length byte, label bytes, then root/type/class on the terminator
	assign jx       = JX'(j_q);
	assign lx       = JX'(run_len_q);
	assign m        = lx + JX'(1) + (term_q ? JX'(TRL_BYTES) : JX'(0));
	assign hi_mem   = (jx != '0) && (jx <= lx);
	assign lo_mem   = (jx + JX'(1)) <= lx;
	assign lo_any   = (jx + JX'(1)) < m;
	assign t_last   = (jx + JX'(2)) >= m;
	assign hi_idx   = jx - lx - JX'(1);
	assign lo_idx   = jx - lx;
	assign hi_fixed = (jx == '0) ? 8'(run_len_q) : trailer_byte(hi_idx[2:0]);
	assign lo_fixed = (lo_any && !lo_mem) ? trailer_byte(lo_idx[2:0]) : 8'h00;
	assign j_m1     = j_q - J_W'(1);

	assign issue_go    = s1_ready && (state_q inside {ST_HDR, ST_TAIL, ST_ABORT});
	assign mem_re      = issue_go && (state_q == ST_TAIL);
	assign mem_raddr_a = j_m1[AW-1:0];
	assign mem_raddr_b = j_q[AW-1:0];

	always_comb begin
		issue = '0;
		case (state_q)
			ST_HDR: begin
				issue.fixed       = hdr_pair(hcnt_q, id_q);
				issue.byte_count  = 2'd2;
				issue.last_of_run = (hcnt_q == HDR_LAST) && !tail_q;
			end
			ST_TAIL: begin
				issue.fixed       = {hi_fixed, lo_fixed};
				issue.hi_mem      = hi_mem;
				issue.lo_mem      = lo_mem;
				issue.byte_count  = lo_any ? 2'd2 : 2'd1;
				issue.last_of_run = t_last;
				issue.packet_end  = t_last && term_q;
			end
			ST_ABORT: begin
				issue.byte_count  = 2'd1;
				issue.last_of_run = 1'b1;
				issue.packet_end  = 1'b1;
				issue.aborted     = 1'b1;
			end
			default: begin
				issue = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hcnt_q     <= '0;
			j_q        <= '0;
			tail_q     <= 1'b0;
			lbl_q      <= '0;
			name_q     <= '0;
			in_query_q <= 1'b0;
			discard_q  <= 1'b0;
			server_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				server_q <= cfg_wr_data;
			end
			if (accept) begin
				hcnt_q <= '0;
				j_q    <= '0;
				tail_q <= tail;
				if (!proc) begin
					if (!in_query_q) begin
						if (!is_end) begin
							in_query_q <= 1'b1;
							discard_q  <= 1'b1;
						end
					end else if (is_end) begin
						in_query_q <= 1'b0;
						discard_q  <= 1'b0;
					end
					state_q <= ST_IDLE;
				end else begin
					in_query_q <= 1'b1;
					discard_q  <= 1'b0;
					lbl_q      <= cur_lbl;
					name_q     <= cur_name;
					if (ab) begin
						discard_q <= 1'b1;
						lbl_q     <= '0;
						name_q    <= '0;
					end else begin
						if (!is_end) begin
							name_q <= cur_name + NM_W'(1);
						end
						if (tail) begin
							lbl_q <= '0;
							if (is_end) begin
								in_query_q <= 1'b0;
								name_q     <= '0;
							end
						end else begin
							lbl_q <= cur_lbl + LBL_W'(1);
						end
					end
					if (start) begin
						state_q <= ST_HDR;
					end else if (ab) begin
						state_q <= ST_ABORT;
					end else if (tail) begin
						state_q <= ST_TAIL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
			end else if (issue_go) begin
				case (state_q)
					ST_HDR: begin
						hcnt_q <= hcnt_q + 3'd1;
						if (hcnt_q == HDR_LAST) begin
							state_q <= tail_q ? ST_TAIL : ST_IDLE;
						end
					end
					ST_TAIL: begin
						j_q <= j_q + J_W'(2);
						if (t_last) begin
							state_q <= ST_IDLE;
						end
					end
					ST_ABORT: begin
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q      <= in_data.query_id;
			run_len_q <= cur_lbl;
			term_q    <= is_end;
		end
	end

endmodule

@@ rtl/dqpb_out.sv @@
module dqpb_out import dqpb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        issue_go,
	input  dqpb_issue_t issue,
	input  logic [7:0]  rdata_a,
	input  logic [7:0]  rdata_b,
	output logic        s1_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output dqpb_out_t   out_data
);

	logic        valid_s1;
	dqpb_issue_t desc_s1;
	logic        out_valid_q;
	dqpb_out_t   out_data_q;
	logic        out_free;
	dqpb_out_t   beat;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_ready = !valid_s1 || out_free;

	// RAM data lines up with desc_s1: the RAM reads only when s1 loads
	always_comb begin
		beat.out_pair[15:8] = desc_s1.hi_mem ? rdata_a : desc_s1.fixed[15:8];
		beat.out_pair[7:0]  = desc_s1.lo_mem ? rdata_b : desc_s1.fixed[7:0];
		beat.byte_count     = desc_s1.byte_count;
		beat.last_of_run    = desc_s1.last_of_run;
		beat.packet_end     = desc_s1.packet_end;
		beat.aborted        = desc_s1.aborted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= issue_go;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && issue_go) begin
			desc_s1 <= issue;
		end
		if (out_free && valid_s1) begin
			out_data_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ bench/tb_dns_query_packet_builder_core.sv @@
module tb_dns_query_packet_builder_core;
	import dqpb_pkg::*;

	localparam int LABEL_MAX      = 63;
	localparam int NAME_LIMIT     = 256;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	dqpb_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	dqpb_out_t   out_data;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_left;
	int unsigned items_sent;
	int unsigned errors;
	int unsigned quiet_cycles;

	// packet builder shadow state
	logic [31:0] srv_addr;
	logic [7:0]  lbl_buf [64];
	int unsigned lbl_len;
	int unsigned name_len;
	bit          in_q;
	bit          dropping;
	dqpb_out_t   pending_beats [$];
	dqpb_out_t   exp_beat;

	dns_query_packet_builder_core #(
		.LABEL_MAX (LABEL_MAX),
		.NAME_LIMIT(NAME_LIMIT)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void predict_char(logic [7:0] c, logic [15:0] id);
		logic [7:0] b [$];
		bit         done;
		dqpb_out_t  r;
		int         i;
		done = 1'b0;
		if (!in_q) begin
			if (srv_addr == '0) begin
				if (c != CHAR_END) begin
					in_q = 1'b1;
					dropping = 1'b1;
				end
				return;
			end
			in_q = 1'b1;
			dropping = 1'b0;
			lbl_len = 0;
			name_len = 0;
			b.push_back(id[15:8]);
			b.push_back(id[7:0]);
			b.push_back(HDR_FLAGS[15:8]);
			b.push_back(HDR_FLAGS[7:0]);
			b.push_back(HDR_QDCOUNT[15:8]);
			b.push_back(HDR_QDCOUNT[7:0]);
			for (i = 0; i < 6; i++) b.push_back(8'h00);
		end else if (dropping) begin
			if (c == CHAR_END) begin
				in_q = 1'b0;
				dropping = 1'b0;
			end
			return;
		end
		if (c != CHAR_END) begin
			if (name_len + 1 >= NAME_LIMIT || (c != CHAR_DOT && lbl_len >= LABEL_MAX)) begin
				dropping = 1'b1;
				lbl_len = 0;
				name_len = 0;
				r = '{out_pair: 16'h0000, byte_count: 2'd1, last_of_run: 1'b1,
					packet_end: 1'b1, aborted: 1'b1};
				pending_beats.push_back(r);
				return;
			end
			name_len++;
		end
		if (c == CHAR_DOT || c == CHAR_END) begin
			b.push_back(8'(lbl_len));
			for (i = 0; i < lbl_len; i++) b.push_back(lbl_buf[i]);
			lbl_len = 0;
			if (c == CHAR_END) begin
				b.push_back(8'h00);
				b.push_back(QTYPE_A[15:8]);
				b.push_back(QTYPE_A[7:0]);
				b.push_back(QCLASS_IN[15:8]);
				b.push_back(QCLASS_IN[7:0]);
				done = 1'b1;
				in_q = 1'b0;
				dropping = 1'b0;
				name_len = 0;
			end
		end else begin
			lbl_buf[lbl_len] = c;
			lbl_len++;
		end
		for (i = 0; i < b.size(); i += 2) begin
			r.last_of_run = (i + 2 >= b.size());
			r.packet_end = r.last_of_run && done;
			r.aborted = 1'b0;
			if (i + 1 < b.size()) begin
				r.out_pair = {b[i], b[i + 1]};
				r.byte_count = 2'd2;
			end else begin
				r.out_pair = {b[i], 8'h00};
				r.byte_count = 2'd1;
			end
			pending_beats.push_back(r);
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_char(in_data.host_char, in_data.query_id);
			if (out_valid && !out_stall) begin
				if (pending_beats.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
				end else begin
					exp_beat = pending_beats.pop_front();
					check_field("out_pair", exp_beat.out_pair, out_data.out_pair);
					check_field("byte_count", 16'(exp_beat.byte_count), 16'(out_data.byte_count));
					check_field("last_of_run", 16'(exp_beat.last_of_run),
						16'(out_data.last_of_run));
					check_field("packet_end", 16'(exp_beat.packet_end), 16'(out_data.packet_end));
					check_field("aborted", 16'(exp_beat.aborted), 16'(out_data.aborted));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: long hold-off when requested, else random stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_char(logic [7:0] c, logic [15:0] id);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{host_char: c, query_id: id};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] label_char();
		logic [7:0] v;
		v = 8'($urandom_range(1, 255));
		if (v == CHAR_DOT) v = 8'h2D;
		return v;
	endfunction

	task automatic send_label(int len, logic [15:0] id);
		int i;
		for (i = 0; i < len; i++) send_char(label_char(), id);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_server(logic [31:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		srv_addr = v;
	endtask

	function automatic logic [31:0] rand_server();
		logic [31:0] v;
		v = $urandom;
		if (v == '0) v = 32'h0000_0001;
		return v;
	endfunction

	task automatic set_idling(int unsigned snd, int unsigned rcv);
		send_idle_pct = snd;
		stall_pct = rcv;
	endtask

	task automatic send_random_query();
		int         kind;
		int         nlabels;
		int         len;
		int         i;
		logic [15:0] id;
		id = 16'($urandom);
		kind = $urandom_range(99);
		if (kind < 85) begin
			nlabels = $urandom_range(1, 3);
			for (i = 0; i < nlabels; i++) begin
				if (i > 0) send_char(CHAR_DOT, id);
				len = $urandom_range(0, 6);
				send_label(len, id);
			end
		end else begin
			len = $urandom_range(1, 6);
			for (i = 0; i < len; i++)
				send_char(($urandom_range(3) == 0) ? CHAR_DOT : 8'($urandom_range(255)), id);
		end
		send_char(CHAR_END, id);
	endtask

	task automatic test_unconfigured();
		set_idling(0, 0);
		send_char(8'h61, 16'h1234);
		send_char(8'h62, 16'h1234);
		send_char(CHAR_END, 16'h1234);
		send_char(CHAR_END, 16'h4321);
	endtask

	task automatic test_header_extremes();
		write_server(32'hFFFF_FFFF);
		send_char(CHAR_END, 16'hFFFF);
		send_char(8'hFF, 16'h0000);
		send_char(CHAR_DOT, 16'hFFFF);
		send_char(8'h01, 16'hFFFF);
		send_char(CHAR_END, 16'hFFFF);
	endtask

	task automatic test_empty_labels();
		send_char(CHAR_DOT, 16'hA5A5);
		send_char(8'h78, 16'hA5A5);
		send_char(CHAR_DOT, 16'hA5A5);
		send_char(CHAR_DOT, 16'hA5A5);
		send_char(CHAR_END, 16'hA5A5);
	endtask

	// server register is only sampled at the first character
	task automatic test_server_change();
		send_char(8'h71, 16'h5A5A);
		write_server(32'h0000_0000);
		send_char(8'h72, 16'h5A5A);
		send_char(CHAR_END, 16'h5A5A);
		send_char(8'h7A, 16'h0F0F);
		write_server(rand_server());
		send_char(8'h79, 16'h0F0F);
		send_char(CHAR_END, 16'h0F0F);
	endtask

	task automatic test_label_limit();
		logic [15:0] id;
		id = 16'($urandom);
		set_idling(15, 15);
		send_label(LABEL_MAX + 1, id);
		send_char(CHAR_END, id);
		wait_idle();
	endtask

	task automatic test_name_limit();
		logic [15:0] id;
		int          i;
		id = 16'($urandom);
		for (i = 0; i < 4; i++) begin
			if (i > 0) send_char(CHAR_DOT, id);
			send_label(LABEL_MAX, id);
		end
		// one more character past the name limit
		send_char(CHAR_DOT, id);
		send_char(CHAR_END, id);
		wait_idle();
	endtask

	task automatic test_backpressure();
		logic [15:0] id;
		int          i;
		set_idling(0, 0);
		wait_idle();
		id = 16'($urandom);
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 3; i++) begin
			send_label(5, id);
			send_char(CHAR_DOT, id);
		end
		send_char(CHAR_END, id);
		wait_idle();
	endtask

	task automatic test_random();
		int          phase;
		int unsigned target;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_idling(0, 0);
					write_server(rand_server());
				end
				1: begin
					set_idling(84, 0);
					write_server(32'h0000_0001);
				end
				2: begin
					set_idling(0, 84);
					write_server(32'hFFFF_FFFF);
				end
				default: begin
					set_idling(15, 15);
					write_server(rand_server());
				end
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) send_random_query();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		items_sent = 0;
		errors = 0;
		quiet_cycles = 0;
		srv_addr = '0;
		lbl_len = 0;
		name_len = 0;
		in_q = 1'b0;
		dropping = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_unconfigured();
		test_header_extremes();
		test_empty_labels();
		test_server_change();
		test_label_limit();
		test_name_limit();
		test_backpressure();
		test_random();
		wait_idle();
		if (pending_beats.size() != 0) errors++;
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dqpb_pkg.sv
rtl/dqpb_ram.sv
rtl/dqpb_seq.sv
rtl/dqpb_out.sv
rtl/dns_query_packet_builder_core.sv
bench/tb_dns_query_packet_builder_core.sv
